/* sv/ses_pkg.sv */
// shared types and constants for the safety escalation supervisor
// used by ses_csr, ses_core and safety_escalation_supervisor; no dependencies
package ses_pkg;

   localparam int IN_DATA_W  = 32;
   localparam int OUT_DATA_W = 40;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] LEVEL_NORMAL     = 2'd0;
   localparam logic [1:0] LEVEL_PRECAUTION = 2'd1;
   localparam logic [1:0] LEVEL_LIMP       = 2'd2;
   localparam logic [1:0] LEVEL_SHUTDOWN   = 2'd3;

   localparam logic       REQ_DIAG     = 1'b0;
   localparam logic       REQ_DETECTOR = 1'b1;

   localparam logic [1:0] ACTION_PRECAUTION = 2'd1;
   localparam logic [1:0] ACTION_LIMP       = 2'd2;

   localparam logic [15:0] SCALE_ONE = 16'd32768;

   localparam logic [7:0]         RECOVERY_COUNT_RST   = 8'd10;
   localparam logic signed [11:0] SHUTDOWN_TEMP_RST    = 12'sd1150;
   localparam logic [15:0]        PRECAUTION_SCALE_RST = 16'd26214;
   localparam logic [15:0]        LIMP_SCALE_RST       = 16'd16384;
   localparam logic [15:0]        SHUTDOWN_SCALE_RST   = 16'd0;

   typedef enum logic [2:0] {
      REG_RECOVERY_COUNT   = 3'd0,
      REG_SHUTDOWN_TEMP    = 3'd1,
      REG_PRECAUTION_SCALE = 3'd2,
      REG_LIMP_SCALE       = 3'd3,
      REG_SHUTDOWN_SCALE   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0]         recovery_count;
      logic signed [11:0] shutdown_temp;
      logic [15:0]        precaution_scale;
      logic [15:0]        limp_scale;
      logic [15:0]        shutdown_scale;
   } cfg_type;

   // first listed member is the top bit, so the data fields line up with tdata
   typedef struct packed {
      logic               req_type;
      logic [1:0]         detector_action;
      logic               detector_active;
      logic signed [11:0] coolant_temp;
      logic               critical_persistent;
      logic [3:0]         confirmed_faults;
      logic [3:0]         pending_faults;
      logic               overheat_crit;
      logic               overheat_warn;
   } in_item_type;

   typedef struct packed {
      logic        accepted;
      logic [15:0] transitions;
      logic [15:0] load_scale;
      logic        shutdown_request;
      logic        torque_derate;
      logic        full_cooling;
      logic [1:0]  requested_level;
      logic [1:0]  current_level;
   } out_item_type;

endpackage

/* sv/safety_escalation_supervisor.sv */
// Safety escalation supervisor. Each item on the req stream is a diagnostic step or a
// detector request; every item yields exactly one result on the rsp stream with the level in
// force, the cooling/derate/shutdown flags, the load scale and the transition count.
// One item is taken every clock cycle unless rsp backpressure stalls the pipeline. An item is
// held in the input register, the level update is done in the logic behind it, and its result is
// registered in the result register, from which it is offered on rsp. Backpressure on rsp stalls
// both registers. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16; the user must
// write them only while idle, as the block itself does not enforce this.
module safety_escalation_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // warning[0], critical[1], pending_faults[5:2], confirmed_faults[9:6],
   // critical_persistent[10], coolant_temp[22:11], detector_active[23],
   // detector_action[25:24], zero fill[31:26]
   input  logic [ses_pkg::IN_DATA_W-1:0]     req_tdata,
   // req_type[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // current_level[1:0], requested_level[3:2], full_cooling[4], torque_derate[5],
   // shutdown_request[6], load_scale[22:7], transitions[38:23], accepted[39]
   output logic [ses_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ses_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ses_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ses_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   ses_pkg::cfg_type      cfg;
   ses_pkg::in_item_type  in_ff, in_in;
   logic                  in_valid_ff, in_valid_in;
   ses_pkg::out_item_type out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;
   ses_pkg::out_item_type result;
   logic                  advance;
   logic                  take;

   ses_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ses_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign take       = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      in_in       = take ? ses_pkg::in_item_type'({req_tuser, req_tdata[25:0]}) : in_ff;
      in_valid_in = take | (in_valid_ff & ~advance);
      out_in      = advance ? result : out_ff;
      out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

endmodule

/* sv/ses_csr.sv */
// configuration registers behind the csr write/read port
// depends on ses_pkg
module ses_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ses_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ses_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ses_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output ses_pkg::cfg_type                  cfg
);

   ses_pkg::cfg_type       cfg_ff;
   ses_pkg::cfg_type       cfg_in;
   ses_pkg::reg_index_type index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign index      = ses_pkg::reg_index_type'(csr_paddr[ses_pkg::CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            ses_pkg::REG_RECOVERY_COUNT:   cfg_in.recovery_count   = csr_pwdata[7:0];
            ses_pkg::REG_SHUTDOWN_TEMP:    cfg_in.shutdown_temp    = $signed(csr_pwdata[11:0]);
            ses_pkg::REG_PRECAUTION_SCALE: cfg_in.precaution_scale = csr_pwdata[15:0];
            ses_pkg::REG_LIMP_SCALE:       cfg_in.limp_scale       = csr_pwdata[15:0];
            ses_pkg::REG_SHUTDOWN_SCALE:   cfg_in.shutdown_scale   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ses_pkg::REG_RECOVERY_COUNT:
            csr_prdata = {24'd0, cfg_ff.recovery_count};
         ses_pkg::REG_SHUTDOWN_TEMP:
            csr_prdata = {{20{cfg_ff.shutdown_temp[11]}}, cfg_ff.shutdown_temp};
         ses_pkg::REG_PRECAUTION_SCALE:
            csr_prdata = {16'd0, cfg_ff.precaution_scale};
         ses_pkg::REG_LIMP_SCALE:
            csr_prdata = {16'd0, cfg_ff.limp_scale};
         ses_pkg::REG_SHUTDOWN_SCALE:
            csr_prdata = {16'd0, cfg_ff.shutdown_scale};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.recovery_count   <= ses_pkg::RECOVERY_COUNT_RST;
         cfg_ff.shutdown_temp    <= ses_pkg::SHUTDOWN_TEMP_RST;
         cfg_ff.precaution_scale <= ses_pkg::PRECAUTION_SCALE_RST;
         cfg_ff.limp_scale       <= ses_pkg::LIMP_SCALE_RST;
         cfg_ff.shutdown_scale   <= ses_pkg::SHUTDOWN_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/ses_core.sv */
// level request rules, escalation state and result fields for one item
// depends on ses_pkg
module ses_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ses_pkg::in_item_type  item,
   input  ses_pkg::cfg_type      cfg,
   output ses_pkg::out_item_type result
);

   logic [1:0]  now_ff, now_in;
   logic [1:0]  asked_ff, asked_in;
   logic [7:0]  run_ff, run_in;
   logic [15:0] count_ff, count_in;

   logic [1:0]  diag_lvl;
   logic [1:0]  det_lvl;
   logic [1:0]  req_lvl;
   logic [7:0]  run_step;
   logic        apply;

   // prioritized diagnostic rules, later rules win
   always_comb begin
      diag_lvl = ses_pkg::LEVEL_NORMAL;
      if (item.overheat_warn || (item.pending_faults[1:0] != 2'd0)) begin
         diag_lvl = ses_pkg::LEVEL_PRECAUTION;
      end
      if (item.overheat_crit || (item.confirmed_faults[2:0] != 3'd0)) begin
         diag_lvl = ses_pkg::LEVEL_LIMP;
      end
      if (item.confirmed_faults[3] && item.critical_persistent &&
          ($signed(item.coolant_temp) >= $signed(cfg.shutdown_temp))) begin
         diag_lvl = ses_pkg::LEVEL_SHUTDOWN;
      end
      // lone coolant sensor fault means the temperature reading is not trusted
      if (item.pending_faults[3] && !item.overheat_warn && !item.overheat_crit &&
          (item.pending_faults[2:0] == 3'd0)) begin
         diag_lvl = ses_pkg::LEVEL_NORMAL;
      end
   end

   always_comb begin
      unique case (item.detector_action)
         ses_pkg::ACTION_PRECAUTION: det_lvl = ses_pkg::LEVEL_PRECAUTION;
         ses_pkg::ACTION_LIMP:       det_lvl = ses_pkg::LEVEL_LIMP;
         default:                    det_lvl = ses_pkg::LEVEL_NORMAL;
      endcase
   end

   always_comb begin
      if (item.req_type == ses_pkg::REQ_DIAG) begin
         req_lvl = diag_lvl;
         apply   = 1'b1;
      end else begin
         req_lvl = (det_lvl > asked_ff) ? det_lvl : asked_ff;
         apply   = item.detector_active;
      end
   end

   assign run_step = run_ff + 8'd1;

   always_comb begin
      now_in   = now_ff;
      asked_in = asked_ff;
      run_in   = run_ff;
      count_in = count_ff;
      if (apply) begin
         asked_in = req_lvl;
         if (req_lvl > now_ff) begin
            now_in   = req_lvl;
            run_in   = 8'd0;
            count_in = count_ff + 16'd1;
         end else if (req_lvl < now_ff) begin
            // a zero count steps down on the first lower request
            if (run_step >= cfg.recovery_count) begin
               now_in   = req_lvl;
               run_in   = 8'd0;
               count_in = count_ff + 16'd1;
            end else begin
               run_in = run_step;
            end
         end else begin
            run_in = 8'd0;
         end
      end
   end

   always_comb begin
      result.current_level    = now_in;
      result.requested_level  = asked_in;
      result.full_cooling     = (now_in != ses_pkg::LEVEL_NORMAL);
      result.torque_derate    = (now_in >= ses_pkg::LEVEL_LIMP);
      result.shutdown_request = (now_in == ses_pkg::LEVEL_SHUTDOWN);
      result.transitions      = count_in;
      result.accepted         = apply;
      case (now_in)
         ses_pkg::LEVEL_PRECAUTION: result.load_scale = cfg.precaution_scale;
         ses_pkg::LEVEL_LIMP:       result.load_scale = cfg.limp_scale;
         ses_pkg::LEVEL_SHUTDOWN:   result.load_scale = cfg.shutdown_scale;
         default:                   result.load_scale = ses_pkg::SCALE_ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= ses_pkg::LEVEL_NORMAL;
         asked_ff <= ses_pkg::LEVEL_NORMAL;
         run_ff   <= 8'd0;
         count_ff <= 16'd0;
      end else if (fire) begin
         now_ff   <= now_in;
         asked_ff <= asked_in;
         run_ff   <= run_in;
         count_ff <= count_in;
      end
   end

   // every level change is counted exactly once
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (now_ff != $past(now_ff))) |-> (count_ff == $past(count_ff) + 16'd1))
      else $error("level changed without a transition count step");

   // a running recovery count only exists while a lower level is asked
   assert property (@(posedge clock) disable iff (reset)
      (run_ff != 8'd0) |-> (asked_ff < now_ff))
      else $error("recovery run active without a lower request");

   // escalation lands exactly on the requested level
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (now_ff > $past(now_ff))) |-> (now_ff == asked_ff))
      else $error("escalated to a level other than the request");

   // state moves only when an item is applied
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(fire)) |-> ($stable(now_ff) && $stable(count_ff)))
      else $error("level state changed without an item");

endmodule
